// File: rtl/ppq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and constants of the pending packet hold queue: request and
// result payloads, the stored slot record, request and result codes, and the
// controller states.
// ----------------------------------------------------------------------------
package ppq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;

  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DEV_W    = 16;
  localparam int unsigned LEN_W    = 7;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ENQUEUE   = 3'd0,
    REQ_SEND      = 3'd1,
    REQ_DROP_ADDR = 3'd2,
    REQ_DROP_DEV  = 3'd3,
    REQ_SHUTDOWN  = 3'd4
  } req_e;

  typedef enum logic [TYPE_W-1:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_SHUTDOWN = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_NONE     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]   req_type;
    logic [HANDLE_W-1:0] packet_handle;
    logic                hook_post_routing;
    logic [ADDR_W-1:0]   dest_addr;
    logic [DEV_W-1:0]    in_dev;
    logic [DEV_W-1:0]    out_dev;
    logic [ADDR_W-1:0]   match_addr;
    logic [DEV_W-1:0]    match_dev;
  } req_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   kind;
    logic [HANDLE_W-1:0] packet_handle_out;
    logic                verdict_accept;
    logic                reroute;
    logic                send_unreachable;
    logic [LEN_W-1:0]    queue_len;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   dest;
    logic                dest_known;
    logic [DEV_W-1:0]    in_dev;
    logic [DEV_W-1:0]    out_dev;
  } slot_t;

endpackage
`default_nettype wire

// File: rtl/pending_packet_hold_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pending_packet_hold_queue_core
// Bounded queue of packets waiting for a route, with release by address,
// drop by device and shutdown.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An enqueue passes through the enqueue
// state and returns one result. A release request (send or drop for an address,
// drop for a device, shutdown) walks the held packets oldest first through the
// slot RAM, a read and an evaluate state per held packet, then a finish state;
// the single read port of that RAM and its registered read set these steps, and
// stalls on the result channel can hold the walk. Packets that stay are written
// back to the next free slot as the walk passes them, so the queue stays
// compacted in age order without a separate pass. Each released packet gives
// one result; one released packet is held back until the next match or the end
// of the walk, so that the final result can carry last. A release that matches
// nothing gives one none-matched result. Only entries below the fill count are
// ever read, so the RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module pending_packet_hold_queue_core #(
  parameter int unsigned QUEUE_DEPTH = ppq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ppq_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ppq_pkg::req_t              in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ppq_pkg::rsp_t                   out_rsp_o
);

  localparam int unsigned SLOT_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LEN_W   = ppq_pkg::LEN_W;

  ppq_pkg::state_e state_q, state_d;
  ppq_pkg::req_t   req_q, req_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             shut_q, shut_d;
  logic [LEN_W-1:0] max_len_q;
  logic             pend_valid_q, pend_valid_d;
  logic [ppq_pkg::HANDLE_W-1:0] pend_handle_q, pend_handle_d;
  logic [LEN_W-1:0] pend_len_q, pend_len_d;
  logic             out_valid_q, out_valid_d;
  ppq_pkg::rsp_t    out_rsp_q, out_rsp_d;

  logic                 ram_we, ram_re;
  logic [SLOT_AW-1:0]   ram_waddr;
  ppq_pkg::slot_t       ram_wdata, ram_rdata, new_slot;

  logic             out_free;
  logic [LEN_W-1:0] limit;
  logic             full, hit, is_end;
  logic             rel_accept, rel_unreach;

  ppq_ram #(
    .WIDTH ($bits(ppq_pkg::slot_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[SLOT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // The result register is free when empty or when its request is being taken.
  assign out_free = !out_valid_q || out_ready_i;

  assign limit = (max_len_q < LEN_W'(QUEUE_DEPTH)) ? max_len_q : LEN_W'(QUEUE_DEPTH);
  assign full  = LEN_W'(held_q) >= limit;

  assign new_slot.handle     = req_q.packet_handle;
  assign new_slot.dest_known = req_q.hook_post_routing;
  assign new_slot.dest       = req_q.hook_post_routing ? req_q.dest_addr : '0;
  assign new_slot.in_dev     = req_q.in_dev;
  assign new_slot.out_dev    = req_q.out_dev;

  assign rel_accept  = req_q.req_type == ppq_pkg::REQ_SEND;
  assign rel_unreach = req_q.req_type == ppq_pkg::REQ_DROP_ADDR;

  // Shared match unit: one stored slot is compared against the request per step.
  // A device index of zero means none and never matches.
  always_comb begin
    case (req_q.req_type) inside
      ppq_pkg::REQ_SEND, ppq_pkg::REQ_DROP_ADDR: begin
        hit = ram_rdata.dest_known && (ram_rdata.dest == req_q.match_addr);
      end
      ppq_pkg::REQ_DROP_DEV: begin
        hit = ((ram_rdata.in_dev != '0) && (ram_rdata.in_dev == req_q.match_dev)) ||
              ((ram_rdata.out_dev != '0) && (ram_rdata.out_dev == req_q.match_dev));
      end
      default: begin
        hit = 1'b1;
      end
    endcase
  end

  assign is_end = (idx_q + CNT_W'(1)) == held_q;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    held_d        = held_q;
    idx_d         = idx_q;
    wr_d          = wr_q;
    rem_d         = rem_q;
    shut_d        = shut_q;
    pend_valid_d  = pend_valid_q;
    pend_handle_d = pend_handle_q;
    pend_len_d    = pend_len_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_rsp_d     = out_rsp_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = wr_q[SLOT_AW-1:0];
    ram_wdata     = ram_rdata;
    in_ready_o    = 1'b0;

    case (state_q)
      ppq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_req_i;
          case (in_req_i.req_type) inside
            ppq_pkg::REQ_ENQUEUE: begin
              state_d = ppq_pkg::ST_ENQ;
            end
            [ppq_pkg::REQ_SEND:ppq_pkg::REQ_SHUTDOWN]: begin
              if (in_req_i.req_type == ppq_pkg::REQ_SHUTDOWN) begin
                shut_d = 1'b1;
              end
              idx_d        = '0;
              wr_d         = '0;
              rem_d        = held_q;
              pend_valid_d = 1'b0;
              state_d      = (held_q == '0) ? ppq_pkg::ST_FINISH : ppq_pkg::ST_READ;
            end
            default: begin
              // Unknown request codes are dropped without a result.
            end
          endcase
        end
      end

      ppq_pkg::ST_ENQ: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_rsp_d.packet_handle_out = req_q.packet_handle;
          out_rsp_d.verdict_accept    = 1'b0;
          out_rsp_d.reroute           = 1'b0;
          out_rsp_d.send_unreachable  = 1'b0;
          out_rsp_d.last              = 1'b1;
          out_rsp_d.queue_len         = LEN_W'(held_q);
          // Fullness is tested before shutdown.
          if (full) begin
            out_rsp_d.kind = ppq_pkg::KIND_FULL;
          end else if (shut_q) begin
            out_rsp_d.kind = ppq_pkg::KIND_SHUTDOWN;
          end else begin
            out_rsp_d.kind      = ppq_pkg::KIND_ACCEPTED;
            out_rsp_d.queue_len = LEN_W'(held_q + CNT_W'(1));
            ram_we              = 1'b1;
            ram_waddr           = held_q[SLOT_AW-1:0];
            ram_wdata           = new_slot;
            held_d              = held_q + CNT_W'(1);
          end
          state_d = ppq_pkg::ST_IDLE;
        end
      end

      ppq_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = ppq_pkg::ST_EVAL;
      end

      ppq_pkg::ST_EVAL: begin
        if (hit) begin
          // A new match pushes the held-back one out, which needs the result register.
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d                 = 1'b1;
              out_rsp_d.kind              = ppq_pkg::KIND_RELEASED;
              out_rsp_d.packet_handle_out = pend_handle_q;
              out_rsp_d.verdict_accept    = rel_accept;
              out_rsp_d.reroute           = rel_accept;
              out_rsp_d.send_unreachable  = rel_unreach;
              out_rsp_d.queue_len         = pend_len_q;
              out_rsp_d.last              = 1'b0;
            end
            pend_valid_d  = 1'b1;
            pend_handle_d = ram_rdata.handle;
            pend_len_d    = LEN_W'(rem_q - CNT_W'(1));
            rem_d         = rem_q - CNT_W'(1);
            idx_d         = idx_q + CNT_W'(1);
            state_d       = is_end ? ppq_pkg::ST_FINISH : ppq_pkg::ST_READ;
          end
        end else begin
          // Kept packets move down to the next free slot.
          ram_we  = 1'b1;
          wr_d    = wr_q + CNT_W'(1);
          idx_d   = idx_q + CNT_W'(1);
          state_d = is_end ? ppq_pkg::ST_FINISH : ppq_pkg::ST_READ;
        end
      end

      ppq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_rsp_d.last = 1'b1;
          if (pend_valid_q) begin
            out_rsp_d.kind              = ppq_pkg::KIND_RELEASED;
            out_rsp_d.packet_handle_out = pend_handle_q;
            out_rsp_d.verdict_accept    = rel_accept;
            out_rsp_d.reroute           = rel_accept;
            out_rsp_d.send_unreachable  = rel_unreach;
            out_rsp_d.queue_len         = pend_len_q;
          end else begin
            out_rsp_d.kind              = ppq_pkg::KIND_NONE;
            out_rsp_d.packet_handle_out = '0;
            out_rsp_d.verdict_accept    = 1'b0;
            out_rsp_d.reroute           = 1'b0;
            out_rsp_d.send_unreachable  = 1'b0;
            out_rsp_d.queue_len         = LEN_W'(wr_q);
          end
          held_d       = wr_q;
          pend_valid_d = 1'b0;
          state_d      = ppq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ppq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ppq_pkg::ST_IDLE;
      held_q       <= '0;
      shut_q       <= 1'b0;
      max_len_q    <= ppq_pkg::MAX_LEN_RESET;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      shut_q       <= shut_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    idx_q         <= idx_d;
    wr_q          <= wr_d;
    rem_q         <= rem_d;
    pend_handle_q <= pend_handle_d;
    pend_len_q    <= pend_len_d;
    out_rsp_q     <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The fill count never passes the RAM depth.
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(QUEUE_DEPTH))
    else $error("held count exceeds queue depth");

  // The write-back pointer never runs ahead of the read index during a walk.
  a_wr_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppq_pkg::ST_READ || state_q == ppq_pkg::ST_EVAL) |-> wr_q <= idx_q)
    else $error("compaction write pointer ahead of scan index");

  // Remaining count equals held count minus the matches seen so far.
  a_rem_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppq_pkg::ST_EVAL) |-> (rem_q + idx_q - wr_q) == held_q)
    else $error("remaining count out of step with the walk");

  // A held-back match is always flushed before returning to idle.
  a_pend_flushed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppq_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("held-back release left pending in idle");

endmodule
`default_nettype wire

// File: rtl/ppq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
